// File: rtl/slab_block_allocator_macros.svh
// ----------------------------------------------------------------------------
// Slab block allocator assertion macros
// Shared property wrappers for the allocator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SLAB_BLOCK_ALLOCATOR_MACROS_SVH
`define SLAB_BLOCK_ALLOCATOR_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define SBA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen out of reset
`define SBA_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/sba_pkg.sv
// ----------------------------------------------------------------------------
// Slab block allocator package
// Types, codes and fixed field widths shared by the allocator files.
// ----------------------------------------------------------------------------
package sba_pkg;

    localparam int DEF_NUM_SLABS  = 16;
    localparam int DEF_MAX_BLOCKS = 64;

    localparam int CMD_W      = 2;
    localparam int SLAB_IDX_W = 4;
    localparam int BLK_IDX_W  = 6;
    localparam int MAXC_W     = 5;
    localparam int POOL_OUT_W = 11;
    localparam int BPS_W      = 7;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [BPS_W-1:0] BPS_RESET = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_ADD    = 2'd2,
        CMD_REMOVE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        Q_DET  = 2'd0,
        Q_FREE = 2'd1,
        Q_PART = 2'd2,
        Q_FULL = 2'd3
    } t_qtag;

    typedef enum logic [0:0] {
        REG_BLOCKS_PER_SLAB = 1'b0
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_EVAL,
        ST_A_BLK,
        ST_F_EVAL,
        ST_CHK,
        ST_ADD_RD,
        ST_WALK,
        ST_RM_RD,
        ST_UNL,
        ST_FIX,
        ST_PSH,
        ST_SELF,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_cmd                  command;
        logic [SLAB_IDX_W-1:0] slab_index;
        logic [BLK_IDX_W-1:0]  block_index;
        logic [MAXC_W-1:0]     max_count;
    } t_req;

    typedef struct packed {
        logic                  ok;
        logic [SLAB_IDX_W-1:0] out_slab;
        logic [BLK_IDX_W-1:0]  out_block;
        logic [MAXC_W-1:0]     done_count;
        logic [POOL_OUT_W-1:0] pool_free_blocks;
    } t_rsp;

    // Field write enables of the slab table
    typedef struct packed {
        logic tag;
        logic link_next;
        logic link_prev;
        logic info;
    } t_slab_wmask;

endpackage

// File: rtl/sba_req_if.sv
// ----------------------------------------------------------------------------
// Slab block allocator request channel
// Valid/ready channel carrying one command request.
// ----------------------------------------------------------------------------
interface sba_req_if;
    logic          valid;
    logic          ready;
    sba_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/sba_rsp_if.sv
// ----------------------------------------------------------------------------
// Slab block allocator response channel
// Valid/ready channel carrying one command result.
// ----------------------------------------------------------------------------
interface sba_rsp_if;
    logic          valid;
    logic          ready;
    sba_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/sba_apb_regs.sv
// ----------------------------------------------------------------------------
// Slab block allocator configuration registers
// APB-style slave holding the blocks-per-slab register.
// ----------------------------------------------------------------------------
module sba_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sba_pkg::PADDR_W-1:0]   paddr,
    input  logic [sba_pkg::PDATA_W-1:0]   pwdata,
    output logic [sba_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [sba_pkg::BPS_W-1:0]     o_bps_raw
);
    logic [sba_pkg::BPS_W-1:0] r_bps;
    logic                      hit;

    assign hit    = (paddr[sba_pkg::PADDR_W-1:2] == sba_pkg::REG_BLOCKS_PER_SLAB);
    assign pready = 1'b1;
    assign prdata = hit ? sba_pkg::PDATA_W'(r_bps) : '0;
    assign o_bps_raw = r_bps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bps <= sba_pkg::BPS_RESET;
        end else if (psel && penable && pwrite && pready && hit) begin
            r_bps <= pwdata[sba_pkg::BPS_W-1:0];
        end
    end
endmodule

// File: rtl/sba_engine.sv
// ----------------------------------------------------------------------------
// Slab block allocator engine
// Sequencer over the slab table and the block link memory.
// ----------------------------------------------------------------------------
`include "slab_block_allocator_macros.svh"

module sba_engine #(
    parameter int NUM_SLABS  = sba_pkg::DEF_NUM_SLABS,
    parameter int MAX_BLOCKS = sba_pkg::DEF_MAX_BLOCKS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    output logic                      o_req_ready,
    input  sba_pkg::t_req             i_req,
    output logic                      o_rsp_valid,
    input  logic                      i_rsp_ready,
    output sba_pkg::t_rsp             o_rsp,
    input  logic [sba_pkg::BPS_W-1:0] i_bps_raw
);
    localparam int SW = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
    localparam int BW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int PW = $clog2(NUM_SLABS * MAX_BLOCKS + 1);
    localparam int BDEPTH = NUM_SLABS * (2 ** BW);

    // Slab table, one entry per slab, field write enables
    sba_pkg::t_qtag m_tag   [NUM_SLABS];
    logic [SW-1:0]  m_next  [NUM_SLABS];
    logic [SW-1:0]  m_prev  [NUM_SLABS];
    logic [CW-1:0]  m_cnt   [NUM_SLABS];
    logic [BW-1:0]  m_bhead [NUM_SLABS];
    logic [BW-1:0]  m_btail [NUM_SLABS];
    // Block link memory, addressed by {slab, block}
    logic [BW-1:0]  m_blk   [BDEPTH];

    sba_pkg::t_qtag r_rd_tag;
    logic [SW-1:0]  r_rd_next, r_rd_prev;
    logic [CW-1:0]  r_rd_cnt;
    logic [BW-1:0]  r_rd_bhead, r_rd_btail;
    logic [BW-1:0]  r_blk_rdata;

    logic                 slab_re;
    logic [SW-1:0]        slab_raddr;
    sba_pkg::t_slab_wmask slab_wm;
    logic [SW-1:0]        slab_waddr;
    sba_pkg::t_qtag       w_tag;
    logic [SW-1:0]        w_next, w_prev;
    logic [CW-1:0]        w_cnt;
    logic [BW-1:0]        w_bhead, w_btail;
    logic                 blk_re, blk_we;
    logic [SW+BW-1:0]     blk_raddr, blk_waddr;
    logic [BW-1:0]        blk_wdata;

    sba_pkg::t_state r_state, n_state;
    sba_pkg::t_req   r_req, n_req;
    logic [SW-1:0]   r_s, n_s, r_clr, n_clr;
    logic [BW-1:0]   r_b, n_b;
    logic [sba_pkg::MAXC_W-1:0] r_done, n_done;
    logic [PW-1:0]   r_pool, n_pool;
    logic            r_ok, n_ok, r_move, n_move, r_was_head, n_was_head;
    logic [SW-1:0]   r_oslab, n_oslab;
    logic [BW-1:0]   r_oblock, n_oblock;
    sba_pkg::t_qtag  r_to, n_to;
    logic [CW-1:0]   r_cnt_new, n_cnt_new;
    logic [BW-1:0]   r_bhead_new, n_bhead_new, r_btail_new, n_btail_new;
    logic [SW-1:0]   r_q_head [4];
    logic [SW-1:0]   n_q_head [4];
    logic [SW-1:0]   r_q_tail [4];
    logic [SW-1:0]   n_q_tail [4];
    logic [3:0]      r_q_valid, n_q_valid;

    logic [CW-1:0]   bps;
    logic            accept, alloc_any, free_in_range, free_ok, chk_go, walk_more;
    logic            head_hit, tail_hit;
    sba_pkg::t_qtag  chk_src;
    logic [SW-1:0]   alloc_s;
    logic [31:0]     oslab_ext, oblock_ext, pool_ext;

    // Saturate the configured block count to 2..MAX_BLOCKS
    always_comb begin
        if (i_bps_raw < sba_pkg::BPS_W'(2)) begin
            bps = CW'(2);
        end else if (32'(i_bps_raw) > MAX_BLOCKS) begin
            bps = CW'(MAX_BLOCKS);
        end else begin
            bps = CW'(i_bps_raw);
        end
    end

    always_comb begin
        accept        = i_req_valid && (r_state == sba_pkg::ST_IDLE);
        alloc_any     = r_q_valid[sba_pkg::Q_PART] || r_q_valid[sba_pkg::Q_FREE];
        alloc_s       = r_q_valid[sba_pkg::Q_PART] ? r_q_head[sba_pkg::Q_PART]
                                                   : r_q_head[sba_pkg::Q_FREE];
        free_in_range = 32'(i_req.slab_index) < NUM_SLABS;
        free_ok       = (r_rd_tag != sba_pkg::Q_DET) && (r_rd_tag != sba_pkg::Q_FREE)
                        && (32'(r_req.block_index) < 32'(bps)) && (r_rd_cnt < bps);
        chk_src       = (r_req.command == sba_pkg::CMD_ADD) ? sba_pkg::Q_DET
                                                            : sba_pkg::Q_FREE;
        chk_go        = (r_done < r_req.max_count) && r_q_valid[chk_src];
        walk_more     = (CW'(r_b) + CW'(1)) < bps;
        head_hit      = r_q_head[r_rd_tag] == r_s;
        tail_hit      = r_q_tail[r_rd_tag] == r_s;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sba_pkg::ST_CLEAR: begin
                if (r_clr == SW'(NUM_SLABS - 1)) n_state = sba_pkg::ST_IDLE;
            end
            sba_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_req.command)
                        sba_pkg::CMD_ALLOC:
                            n_state = alloc_any ? sba_pkg::ST_A_EVAL : sba_pkg::ST_DONE;
                        sba_pkg::CMD_FREE:
                            n_state = free_in_range ? sba_pkg::ST_F_EVAL : sba_pkg::ST_DONE;
                        default: n_state = sba_pkg::ST_CHK;
                    endcase
                end
            end
            sba_pkg::ST_A_EVAL: begin
                if (r_rd_cnt == '0) begin
                    n_state = sba_pkg::ST_DONE;
                end else if (r_rd_cnt > CW'(1)) begin
                    n_state = sba_pkg::ST_A_BLK;
                end else begin
                    n_state = sba_pkg::ST_UNL;
                end
            end
            sba_pkg::ST_A_BLK: n_state = r_move ? sba_pkg::ST_UNL : sba_pkg::ST_SELF;
            sba_pkg::ST_F_EVAL: begin
                if (!free_ok) begin
                    n_state = sba_pkg::ST_DONE;
                end else if ((r_rd_cnt == '0) || (r_rd_cnt + CW'(1) == bps)) begin
                    n_state = sba_pkg::ST_UNL;
                end else begin
                    n_state = sba_pkg::ST_SELF;
                end
            end
            sba_pkg::ST_CHK: begin
                if (!chk_go) begin
                    n_state = sba_pkg::ST_DONE;
                end else if (r_req.command == sba_pkg::CMD_ADD) begin
                    n_state = sba_pkg::ST_ADD_RD;
                end else begin
                    n_state = sba_pkg::ST_RM_RD;
                end
            end
            sba_pkg::ST_ADD_RD: n_state = sba_pkg::ST_WALK;
            sba_pkg::ST_WALK:   n_state = walk_more ? sba_pkg::ST_WALK : sba_pkg::ST_UNL;
            sba_pkg::ST_RM_RD:  n_state = sba_pkg::ST_UNL;
            sba_pkg::ST_UNL:    n_state = sba_pkg::ST_FIX;
            sba_pkg::ST_FIX:    n_state = sba_pkg::ST_PSH;
            sba_pkg::ST_PSH:    n_state = sba_pkg::ST_SELF;
            sba_pkg::ST_SELF: begin
                if ((r_req.command == sba_pkg::CMD_ADD)
                        || (r_req.command == sba_pkg::CMD_REMOVE)) begin
                    n_state = sba_pkg::ST_CHK;
                end else begin
                    n_state = sba_pkg::ST_DONE;
                end
            end
            sba_pkg::ST_DONE: if (i_rsp_ready) n_state = sba_pkg::ST_IDLE;
            default: n_state = sba_pkg::ST_IDLE;
        endcase
    end

    // Outputs, memory strobes and datapath
    always_comb begin
        n_req = r_req;   n_s = r_s;     n_clr = r_clr;   n_b = r_b;
        n_done = r_done; n_pool = r_pool; n_ok = r_ok;   n_move = r_move;
        n_was_head = r_was_head; n_oslab = r_oslab; n_oblock = r_oblock;
        n_to = r_to; n_cnt_new = r_cnt_new;
        n_bhead_new = r_bhead_new; n_btail_new = r_btail_new;
        n_q_head = r_q_head; n_q_tail = r_q_tail; n_q_valid = r_q_valid;

        o_req_ready = 1'b0;
        o_rsp_valid = 1'b0;
        slab_re    = 1'b0;
        slab_raddr = r_s;
        slab_wm    = '0;
        slab_waddr = r_s;
        w_tag      = r_rd_tag;
        w_next     = r_rd_next;
        w_prev     = r_rd_prev;
        w_cnt      = r_cnt_new;
        w_bhead    = r_bhead_new;
        w_btail    = r_btail_new;
        blk_re     = 1'b0;
        blk_raddr  = {r_s, r_rd_bhead};
        blk_we     = 1'b0;
        blk_waddr  = {r_s, r_b};
        blk_wdata  = r_b + BW'(1);

        unique case (r_state)
            sba_pkg::ST_CLEAR: begin
                slab_wm    = '1;
                slab_waddr = r_clr;
                w_tag      = sba_pkg::Q_DET;
                w_next     = r_clr + SW'(1);
                w_prev     = r_clr - SW'(1);
                w_cnt      = '0;
                w_bhead    = '0;
                w_btail    = '0;
                n_clr      = r_clr + SW'(1);
            end
            sba_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (accept) begin
                    n_req    = i_req;
                    n_ok     = 1'b1;
                    n_oslab  = '0;
                    n_oblock = '0;
                    n_done   = '0;
                    n_move   = 1'b0;
                    if (i_req.command == sba_pkg::CMD_ALLOC) begin
                        if (alloc_any) begin
                            slab_re    = 1'b1;
                            slab_raddr = alloc_s;
                            n_s        = alloc_s;
                        end else begin
                            n_ok = 1'b0;
                        end
                    end else if ((i_req.command == sba_pkg::CMD_FREE) && free_in_range) begin
                        slab_re    = 1'b1;
                        slab_raddr = SW'(i_req.slab_index);
                        n_s        = SW'(i_req.slab_index);
                    end
                end
            end
            sba_pkg::ST_A_EVAL: begin
                if (r_rd_cnt == '0) begin
                    n_ok = 1'b0;
                end else begin
                    n_oslab     = r_s;
                    n_oblock    = r_rd_bhead;
                    n_pool      = r_pool - PW'(1);
                    n_cnt_new   = r_rd_cnt - CW'(1);
                    n_bhead_new = r_rd_bhead;
                    n_btail_new = r_rd_btail;
                    blk_re      = (r_rd_cnt > CW'(1));
                    n_move      = (r_rd_cnt == CW'(1)) || (r_rd_tag == sba_pkg::Q_FREE);
                    n_to        = (r_rd_cnt == CW'(1)) ? sba_pkg::Q_FULL : sba_pkg::Q_PART;
                end
            end
            sba_pkg::ST_A_BLK: begin
                n_bhead_new = r_blk_rdata;
            end
            sba_pkg::ST_F_EVAL: begin
                if (free_ok) begin
                    if (r_rd_cnt == '0) begin
                        n_bhead_new = BW'(r_req.block_index);
                    end else begin
                        n_bhead_new = r_rd_bhead;
                        blk_we      = 1'b1;
                        blk_waddr   = {r_s, r_rd_btail};
                        blk_wdata   = BW'(r_req.block_index);
                    end
                    n_btail_new = BW'(r_req.block_index);
                    n_cnt_new   = r_rd_cnt + CW'(1);
                    n_pool      = r_pool + PW'(1);
                    n_move      = (r_rd_cnt == '0) || (r_rd_cnt + CW'(1) == bps);
                    n_to        = (r_rd_cnt == '0) ? sba_pkg::Q_PART : sba_pkg::Q_FREE;
                end
            end
            sba_pkg::ST_CHK: begin
                if (chk_go) begin
                    slab_re    = 1'b1;
                    slab_raddr = r_q_head[chk_src];
                    n_s        = r_q_head[chk_src];
                end
            end
            sba_pkg::ST_ADD_RD: begin
                n_cnt_new   = bps;
                n_bhead_new = '0;
                n_btail_new = BW'(bps - CW'(1));
                n_pool      = r_pool + PW'(bps);
                n_b         = '0;
                n_move      = 1'b1;
                n_to        = sba_pkg::Q_FREE;
            end
            sba_pkg::ST_WALK: begin
                // Chain the fresh slab's blocks in index order
                if (walk_more) begin
                    blk_we = 1'b1;
                    n_b    = r_b + BW'(1);
                end
            end
            sba_pkg::ST_RM_RD: begin
                n_pool      = r_pool - PW'(r_rd_cnt);
                n_cnt_new   = '0;
                n_bhead_new = r_rd_bhead;
                n_btail_new = r_rd_btail;
                n_move      = 1'b1;
                n_to        = sba_pkg::Q_DET;
            end
            sba_pkg::ST_UNL: begin
                // Unlink from the old queue: head pointer or predecessor's link
                n_was_head = head_hit;
                if (head_hit) begin
                    if (tail_hit) begin
                        n_q_valid[r_rd_tag] = 1'b0;
                    end else begin
                        n_q_head[r_rd_tag] = r_rd_next;
                    end
                end else begin
                    slab_wm.link_next = 1'b1;
                    slab_waddr        = r_rd_prev;
                    w_next            = r_rd_next;
                end
            end
            sba_pkg::ST_FIX: begin
                if (!r_was_head) begin
                    if (tail_hit) begin
                        n_q_tail[r_rd_tag] = r_rd_prev;
                    end else begin
                        slab_wm.link_prev = 1'b1;
                        slab_waddr        = r_rd_next;
                        w_prev            = r_rd_prev;
                    end
                end
            end
            sba_pkg::ST_PSH: begin
                if (!r_q_valid[r_to]) begin
                    n_q_head[r_to]  = r_s;
                    n_q_valid[r_to] = 1'b1;
                end else begin
                    slab_wm.link_next = 1'b1;
                    slab_waddr        = r_q_tail[r_to];
                    w_next            = r_s;
                end
            end
            sba_pkg::ST_SELF: begin
                slab_wm.tag       = 1'b1;
                slab_wm.link_prev = 1'b1;
                slab_wm.info      = 1'b1;
                if (r_move) begin
                    w_tag          = r_to;
                    w_prev         = r_q_tail[r_to];
                    n_q_tail[r_to] = r_s;
                end
                if ((r_req.command == sba_pkg::CMD_ADD)
                        || (r_req.command == sba_pkg::CMD_REMOVE)) begin
                    n_done = r_done + sba_pkg::MAXC_W'(1);
                end
            end
            sba_pkg::ST_DONE: begin
                o_rsp_valid = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        oslab_ext  = 32'(r_oslab);
        oblock_ext = 32'(r_oblock);
        pool_ext   = 32'(r_pool);
        o_rsp.ok               = r_ok;
        o_rsp.out_slab         = oslab_ext[sba_pkg::SLAB_IDX_W-1:0];
        o_rsp.out_block        = oblock_ext[sba_pkg::BLK_IDX_W-1:0];
        o_rsp.done_count       = r_done;
        o_rsp.pool_free_blocks = pool_ext[sba_pkg::POOL_OUT_W-1:0];
    end

    // Slab table and block link memory
    always_ff @(posedge i_clk) begin
        if (slab_re) begin
            r_rd_tag   <= m_tag[slab_raddr];
            r_rd_next  <= m_next[slab_raddr];
            r_rd_prev  <= m_prev[slab_raddr];
            r_rd_cnt   <= m_cnt[slab_raddr];
            r_rd_bhead <= m_bhead[slab_raddr];
            r_rd_btail <= m_btail[slab_raddr];
        end
        if (slab_wm.tag)       m_tag[slab_waddr]  <= w_tag;
        if (slab_wm.link_next) m_next[slab_waddr] <= w_next;
        if (slab_wm.link_prev) m_prev[slab_waddr] <= w_prev;
        if (slab_wm.info) begin
            m_cnt[slab_waddr]   <= w_cnt;
            m_bhead[slab_waddr] <= w_bhead;
            m_btail[slab_waddr] <= w_btail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (blk_re) r_blk_rdata <= m_blk[blk_raddr];
        if (blk_we) m_blk[blk_waddr] <= blk_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sba_pkg::ST_CLEAR;
            r_clr     <= '0;
            r_done    <= '0;
            r_pool    <= '0;
            r_q_valid <= 4'b0001;
            for (int q = 0; q < 4; q++) begin
                r_q_head[q] <= '0;
                r_q_tail[q] <= (q == int'(sba_pkg::Q_DET)) ? SW'(NUM_SLABS - 1) : '0;
            end
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_done    <= n_done;
            r_pool    <= n_pool;
            r_q_valid <= n_q_valid;
            r_q_head  <= n_q_head;
            r_q_tail  <= n_q_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_s         <= n_s;
        r_b         <= n_b;
        r_ok        <= n_ok;
        r_move      <= n_move;
        r_was_head  <= n_was_head;
        r_oslab     <= n_oslab;
        r_oblock    <= n_oblock;
        r_to        <= n_to;
        r_cnt_new   <= n_cnt_new;
        r_bhead_new <= n_bhead_new;
        r_btail_new <= n_btail_new;
    end

    `SBA_ASSERT(a_done_hold, i_clk, i_rst_n, (r_state == sba_pkg::ST_DONE && !i_rsp_ready) |=> (r_state == sba_pkg::ST_DONE), "result dropped while stalled")
    `SBA_ASSERT(a_push_valid, i_clk, i_rst_n, (r_state == sba_pkg::ST_SELF && r_move) |=> r_q_valid[r_to], "target queue empty after requeue")
    `SBA_ASSERT(a_done_max, i_clk, i_rst_n, (r_state == sba_pkg::ST_CHK) |-> (r_done <= r_req.max_count), "slab walk overran its count")
    `SBA_NEVER(a_blk_addr, i_clk, i_rst_n, blk_we && (32'(r_s) >= NUM_SLABS), "block link write outside the pool")
endmodule

// File: rtl/slab_block_allocator.sv
// ----------------------------------------------------------------------------
// Slab block allocator
// Top level: request and response channels, configuration port, result register.
// ----------------------------------------------------------------------------
// One request at a time. After reset the slab table is initialised, one
// slab at a time, before the first request is taken. The time an alloc or
// a free takes from acceptance to result varies. The spread comes from
// the single write port of the slab table: one read, then up to four writes
// to requeue the slab. An alloc on an empty pool and an ignored free answer
// without requeueing. Add and remove walk their queue slab by slab; add
// writes one block link a cycle for each slab attached. The result sits in
// an output register, so a new request is taken while the last result waits.
module slab_block_allocator #(
    parameter int NUM_SLABS  = sba_pkg::DEF_NUM_SLABS,
    parameter int MAX_BLOCKS = sba_pkg::DEF_MAX_BLOCKS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    sba_req_if.sink                     i_req,
    sba_rsp_if.source                   o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sba_pkg::PADDR_W-1:0] paddr,
    input  logic [sba_pkg::PDATA_W-1:0] pwdata,
    output logic [sba_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    logic [sba_pkg::BPS_W-1:0] bps_raw;
    logic                      eng_ready, eng_rsp_valid, eng_rsp_ready;
    sba_pkg::t_rsp             eng_rsp;
    logic                      r_out_valid;
    sba_pkg::t_rsp             r_out_data;

    sba_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_bps_raw (bps_raw)
    );

    sba_engine #(
        .NUM_SLABS  (NUM_SLABS),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (eng_ready),
        .i_req       (i_req.payload),
        .o_rsp_valid (eng_rsp_valid),
        .i_rsp_ready (eng_rsp_ready),
        .o_rsp       (eng_rsp),
        .i_bps_raw   (bps_raw)
    );

    assign i_req.ready   = eng_ready;
    // Take a new result when the register is empty or drains this cycle
    assign eng_rsp_ready = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_rsp_valid && eng_rsp_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_rsp_valid && eng_rsp_ready) begin
            r_out_data <= eng_rsp;
        end
    end
endmodule
